@@ rtl/core/spw_pkg.sv @@
// Shared types, constants and helpers for the servo pulse width block.
package spw_pkg;

   // Default width of the microsecond time registers
   localparam int TIME_BITS_DEF = 16;

   // Register reset values
   localparam int PULSE_MIN_RST    = 850;
   localparam int PULSE_MAX_RST    = 2150;
   localparam int STEP_COUNT_RST   = 1024;
   localparam int FRAME_PERIOD_RST = 20000;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_PULSE_MIN    = 2'd0;
   localparam logic [1:0] CSR_PULSE_MAX    = 2'd1;
   localparam logic [1:0] CSR_STEP_COUNT   = 2'd2;
   localparam logic [1:0] CSR_FRAME_PERIOD = 2'd3;

   // Request kinds
   localparam logic [1:0] REQ_SET     = 2'd0;
   localparam logic [1:0] REQ_REFRESH = 2'd1;
   localparam logic [1:0] REQ_RECONF  = 2'd2;

   // Position steps, one multiplier bit per step
   localparam int MUL_STEPS = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_SUM,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic go;        // transaction produces a result
      logic out_free;  // output register can take a result this cycle
   } seq_status_type;

   typedef struct packed {
      logic idle;
      logic clamp;
      logic mul;
      logic prep;
      logic div;
      logic sum;
      logic emit;
   } seq_ctrl_type;

   // Microseconds to nanoseconds, low 26 bits kept
   function automatic logic [25:0] us_to_ns(input logic [31:0] us);
      logic [31:0] prod;
      prod = (us << 10) - (us << 5) + (us << 3);
      return prod[25:0];
   endfunction

endpackage

@@ rtl/core/spw_addsub.sv @@
// Shared adder/subtractor used by the multiply, divide and sum steps of the sequencer.
module spw_addsub #(
   parameter int WIDTH = 17
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             sub,
   output logic [WIDTH:0]   res
);

   logic [WIDTH:0] b_ext;

   // Top bit of res is the borrow when subtracting
   always_comb begin
      b_ext = sub ? (~{1'b0, b} + {{WIDTH{1'b0}}, 1'b1}) : {1'b0, b};
      res   = {1'b0, a} + b_ext;
   end

endmodule

@@ rtl/core/spw_seq.sv @@
// Sequencer that walks one transaction through clamp, multiply, divide and sum.
module spw_seq
   import spw_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  seq_status_type status,
   output seq_ctrl_type   ctrl
);

   localparam int CNT_MAX = (TIME_BITS > MUL_STEPS) ? TIME_BITS : MUL_STEPS;
   localparam int CW      = $clog2(CNT_MAX);

   seq_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CLAMP;
         ST_CLAMP: state_in = status.go ? ST_MUL : ST_IDLE;
         ST_MUL:   if (cnt_ff == '0) state_in = ST_PREP;
         ST_PREP:  state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == '0) state_in = ST_SUM;
         ST_SUM:   state_in = ST_EMIT;
         ST_EMIT:  if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Step counter
   always_comb begin
      cnt_in = cnt_ff;
      case (state_ff)
         ST_CLAMP: cnt_in = CW'(MUL_STEPS - 1);
         ST_MUL:   cnt_in = cnt_ff - 1'b1;
         ST_PREP:  cnt_in = CW'(TIME_BITS - 1);
         ST_DIV:   cnt_in = cnt_ff - 1'b1;
         default:  cnt_in = cnt_ff;
      endcase
   end

   // Outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:  ctrl.idle  = 1'b1;
         ST_CLAMP: ctrl.clamp = 1'b1;
         ST_MUL:   ctrl.mul   = 1'b1;
         ST_PREP:  ctrl.prep  = 1'b1;
         ST_DIV:   ctrl.div   = 1'b1;
         ST_SUM:   ctrl.sum   = 1'b1;
         ST_EMIT:  ctrl.emit  = status.out_free;
         default:  ctrl = '0;
      endcase
   end

endmodule

@@ rtl/core/servo_position_to_pulse_width.sv @@
// Servo position to PWM pulse width converter, top level.
//
// Takes a signed step position (or a refresh / reconfigure request), clamps it
// to the step window set by step_count, maps it linearly between pulse_min_us
// and pulse_max_us and returns the pulse width and, on reconfigure, the frame
// period, both in nanoseconds. The multiply, divide and final sum run through
// one shared adder/subtractor: a 16-step shift-add multiply of the window
// offset by the pulse span, then a TIME_BITS-step restoring divide by
// step_count. A request that yields a result passes through the clamp,
// multiply, prep, divide, sum and emit states, and the next request can be
// taken once the result has moved into the output register. A set that leaves
// the position unchanged, or an unused request kind, produces no result, and
// the block returns to idle straight after the clamp state. One transaction is
// in flight at a time; req_stall stays high from accept until the result has
// moved into the output register, which then holds it under rsp_stall while
// the next request is taken. The user must write the csr registers only while
// the block is idle; the block itself does not enforce this.
module servo_position_to_pulse_width
   import spw_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic signed [15:0]  req_position,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [25:0]         rsp_duty_ns,
   output logic [25:0]         rsp_period_ns,
   output logic                rsp_reconfigure,
   output logic signed [15:0]  rsp_applied_position,
   // configuration
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   // Shared unit width: pulse accumulate needs TIME_BITS+1, divide step 17
   localparam int AW = (TIME_BITS + 1 > 17) ? TIME_BITS + 1 : 17;
   localparam int PW = MUL_STEPS + TIME_BITS;

   seq_ctrl_type   ctrl;
   seq_status_type status;

   // configuration registers
   logic [TIME_BITS-1:0] pulse_min_ff, pulse_max_ff, period_ff;
   logic [15:0]          step_count_ff;

   // transaction and position state
   logic [1:0]           kind_ff;
   logic signed [15:0]   pos_ff;
   logic signed [15:0]   cur_pos_ff;
   logic                 reconf_ff;

   // arithmetic working registers
   logic                 neg_ff;
   logic [TIME_BITS-1:0] mag_ff;
   logic [TIME_BITS:0]   hi_ff, hi_in;
   logic [15:0]          lo_ff, lo_in;
   logic [15:0]          rem_ff, rem_in;
   logic [TIME_BITS-1:0] qsh_ff, qsh_in;
   logic [TIME_BITS-1:0] us_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [25:0]          duty_ff, period_ns_ff;
   logic                 rsp_reconf_ff;
   logic signed [15:0]   applied_ff;

   // clamp window and mapping setup
   logic signed [15:0]   half_s, win_lo, win_hi, src_pos, clamped;
   logic [16:0]          off_wide;
   logic [TIME_BITS:0]   span;
   logic                 unchanged;

   // shared unit operands
   logic [AW-1:0]        alu_a, alu_b;
   logic                 alu_sub;
   logic [AW:0]          alu_res;
   logic [PW-1:0]        product;
   logic [TIME_BITS-1:0] quotient;
   logic                 borrow;

   spw_seq #(
      .TIME_BITS (TIME_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   spw_addsub #(
      .WIDTH (AW)
   ) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .res (alu_res)
   );

   // Step window: odd count is symmetric, even count loses the top step
   always_comb begin
      half_s  = $signed({1'b0, step_count_ff[15:1]});
      win_lo  = (step_count_ff == '0) ? 16'sd0 : -half_s;
      if (step_count_ff == '0) begin
         win_hi = 16'sd0;
      end else if (step_count_ff[0]) begin
         win_hi = half_s;
      end else begin
         win_hi = half_s - 16'sd1;
      end
      src_pos = (kind_ff == REQ_SET) ? pos_ff : cur_pos_ff;
      if (src_pos < win_lo) begin
         clamped = win_lo;
      end else if (src_pos > win_hi) begin
         clamped = win_hi;
      end else begin
         clamped = src_pos;
      end
      off_wide  = {clamped[15], clamped} - {win_lo[15], win_lo};
      span      = {1'b0, pulse_max_ff} - {1'b0, pulse_min_ff};
      unchanged = (clamped == cur_pos_ff);
   end

   // A set that moves the position, or a refresh / reconfigure, gives a result
   always_comb begin
      status.go       = (kind_ff == REQ_SET) ? !unchanged
                        : (kind_ff == REQ_REFRESH || kind_ff == REQ_RECONF);
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign product  = {hi_ff[TIME_BITS-1:0], lo_ff};
   assign quotient = (step_count_ff == '0) ? '0 : qsh_ff;
   assign borrow   = alu_res[AW];

   // Shared unit operand select
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      if (ctrl.mul) begin
         // accumulate span when the current multiplier bit is set
         alu_a = AW'(hi_ff);
         alu_b = lo_ff[0] ? AW'(mag_ff) : '0;
      end else if (ctrl.div) begin
         // trial subtract of step_count from the shifted remainder
         alu_a   = AW'({rem_ff, qsh_ff[TIME_BITS-1]});
         alu_b   = AW'(step_count_ff);
         alu_sub = 1'b1;
      end else if (ctrl.sum) begin
         // quotient rounds toward zero, so apply the span sign after dividing
         alu_a   = AW'(pulse_min_ff);
         alu_b   = AW'(quotient);
         alu_sub = neg_ff;
      end
   end

   // Working register next values
   always_comb begin
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      rem_in = rem_ff;
      qsh_in = qsh_ff;
      if (ctrl.clamp) begin
         hi_in = '0;
         lo_in = off_wide[15:0];
      end else if (ctrl.mul) begin
         hi_in = {1'b0, alu_res[TIME_BITS:1]};
         lo_in = {alu_res[0], lo_ff[15:1]};
      end else if (ctrl.prep) begin
         rem_in = product[PW-1:TIME_BITS];
         qsh_in = product[TIME_BITS-1:0];
      end else if (ctrl.div) begin
         rem_in = borrow ? {rem_ff[14:0], qsh_ff[TIME_BITS-1]} : alu_res[15:0];
         qsh_in = {qsh_ff[TIME_BITS-2:0], !borrow};
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff  <= TIME_BITS'(PULSE_MIN_RST);
         pulse_max_ff  <= TIME_BITS'(PULSE_MAX_RST);
         step_count_ff <= 16'(STEP_COUNT_RST);
         period_ff     <= TIME_BITS'(FRAME_PERIOD_RST);
         cur_pos_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PULSE_MIN:    pulse_min_ff  <= TIME_BITS'(csr_wdata);
               CSR_PULSE_MAX:    pulse_max_ff  <= TIME_BITS'(csr_wdata);
               CSR_STEP_COUNT:   step_count_ff <= csr_wdata;
               CSR_FRAME_PERIOD: period_ff     <= TIME_BITS'(csr_wdata);
               default: ;
            endcase
         end
         // store the clamped position once the transaction is known to emit
         if (ctrl.clamp && status.go) begin
            cur_pos_ff <= clamped;
         end
         // hold the result until taken, then drop or refill
         if (ctrl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctrl.idle && req_valid) begin
         kind_ff <= req_type;
         pos_ff  <= req_position;
      end
      if (ctrl.clamp) begin
         reconf_ff <= (kind_ff == REQ_RECONF);
         neg_ff    <= span[TIME_BITS];
         mag_ff    <= span[TIME_BITS] ? TIME_BITS'(-span) : span[TIME_BITS-1:0];
      end
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      rem_ff <= rem_in;
      qsh_ff <= qsh_in;
      // result stays inside the pulse range, so it never goes negative
      if (ctrl.sum) begin
         us_ff <= alu_res[TIME_BITS-1:0];
      end
      if (ctrl.emit) begin
         duty_ff       <= us_to_ns(32'(us_ff));
         period_ns_ff  <= reconf_ff ? us_to_ns(32'(period_ff)) : '0;
         rsp_reconf_ff <= reconf_ff;
         applied_ff    <= cur_pos_ff;
      end
   end

   assign req_stall            = !ctrl.idle;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_duty_ns          = duty_ff;
   assign rsp_period_ns        = period_ns_ff;
   assign rsp_reconfigure      = rsp_reconf_ff;
   assign rsp_applied_position = applied_ff;

endmodule
